@@ hw/rtl/arp_pkg.sv @@
// types and constants shared by the aarch64 relocation patcher
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

    // elf relocation type codes
    localparam logic [31:0] RT_ABS64  = 32'd257;
    localparam logic [31:0] RT_ABS32  = 32'd258;
    localparam logic [31:0] RT_ADRP   = 32'd275;
    localparam logic [31:0] RT_ADDLO  = 32'd277;
    localparam logic [31:0] RT_JUMP26 = 32'd282;
    localparam logic [31:0] RT_CALL26 = 32'd283;

    // status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_ABS64_BAD      = 4'd1;
    localparam logic [3:0] ST_ABS32_BAD      = 4'd2;
    localparam logic [3:0] ST_BR_MISALIGNED  = 4'd3;
    localparam logic [3:0] ST_BR_RANGE       = 4'd4;
    localparam logic [3:0] ST_NOT_BRANCH     = 4'd5;
    localparam logic [3:0] ST_ADRP_NEGATIVE  = 4'd6;
    localparam logic [3:0] ST_ADRP_RANGE     = 4'd7;
    localparam logic [3:0] ST_NOT_ADRP       = 4'd8;
    localparam logic [3:0] ST_ADD_NEGATIVE   = 4'd9;
    localparam logic [3:0] ST_NOT_ADD        = 4'd10;
    localparam logic [3:0] ST_UNSUPPORTED    = 4'd11;

    // instruction encodings and masks
    localparam logic [31:0] OP_BL        = 32'h9400_0000;
    localparam logic [31:0] OP_B         = 32'h1400_0000;
    localparam logic [31:0] MASK_BRANCH  = 32'hfc00_0000;
    localparam logic [31:0] MASK_ADRP    = 32'h9f00_0000;
    localparam logic [31:0] OP_ADRP      = 32'h9000_0000;
    localparam logic [31:0] IMM_ADRP     = 32'h60ff_ffe0;
    localparam logic [31:0] MASK_ADD     = 32'h7f40_0000;
    localparam logic [31:0] OP_ADD       = 32'h1100_0000;
    localparam logic [31:0] IMM_ADD      = 32'h003f_fc00;

    typedef enum logic [2:0] {
        KIND_ABS64,
        KIND_ABS32,
        KIND_CALL,
        KIND_JUMP,
        KIND_ADRP,
        KIND_ADDLO,
        KIND_UNSUP
    } kind_t;

    typedef struct packed {
        logic [31:0]        opcode;
        logic [63:0]        place_addr;
        logic [63:0]        sym_value;
        logic signed [63:0] addend;
        logic [2:0]         offset_low_bits;
        logic [31:0]        existing_word;
    } item_t;

    typedef struct packed {
        logic [63:0] patched_word;
        logic        wide_write;
        logic [3:0]  status;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/aarch64_relocation_patcher_core.sv @@
// three stage pipelined aarch64 rela relocation patcher
// throughput: one transaction per cycle; the 64-bit symbol add, the place and page
// subtracts and the check/format logic each take one register stage
// busy stays low: the receiver cannot stall, so nothing backs up
// reset clears the valid bits of all stages; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module aarch64_relocation_patcher_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire arp_pkg::item_t    item,
    output logic                   result_valid,
    output arp_pkg::result_t       result
);

    // stage 1: symbol + addend
    logic                  s1_valid_reg;
    arp_pkg::kind_t        s1_kind_reg;
    logic [63:0]           s1_lo_reg;
    logic                  s1_hi_neg_reg;
    logic                  s1_hi_pos_reg;
    logic [63:0]           s1_place_reg;
    logic [2:0]            s1_offs_reg;
    logic [31:0]           s1_word_reg;

    // stage 2: distances
    logic                  s2_valid_reg;
    arp_pkg::kind_t        s2_kind_reg;
    logic [63:0]           s2_lo_reg;
    logic                  s2_hi_neg_reg;
    logic                  s2_hi_pos_reg;
    logic [2:0]            s2_offs_reg;
    logic [31:0]           s2_word_reg;
    logic [63:0]           s2_br_dist_reg;
    logic                  s2_br_borrow_reg;
    logic [51:0]           s2_pg_dist_reg;
    logic                  s2_pg_neg_reg;

    // stage 3: output
    logic                  result_valid_reg;
    arp_pkg::result_t      result_reg;

    logic                  accept;
    logic [64:0]           sum_next;
    arp_pkg::kind_t        kind_next;
    logic [64:0]           br_diff_next;
    logic [52:0]           pg_diff_next;
    arp_pkg::result_t      result_next;

    logic                  hi_zero;
    logic                  dhi_zero;
    logic                  dhi_minus1;
    logic                  br_in_range;
    logic                  pg_in_range;
    logic [31:0]           br_op;
    logic [20:0]           pg_imm;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        sum_next = {1'b0, item.sym_value} + {1'b0, item.addend};
        case (item.opcode)
            arp_pkg::RT_ABS64:  kind_next = arp_pkg::KIND_ABS64;
            arp_pkg::RT_ABS32:  kind_next = arp_pkg::KIND_ABS32;
            arp_pkg::RT_CALL26: kind_next = arp_pkg::KIND_CALL;
            arp_pkg::RT_JUMP26: kind_next = arp_pkg::KIND_JUMP;
            arp_pkg::RT_ADRP:   kind_next = arp_pkg::KIND_ADRP;
            arp_pkg::RT_ADDLO:  kind_next = arp_pkg::KIND_ADDLO;
            default:            kind_next = arp_pkg::KIND_UNSUP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind_next;
            s1_lo_reg     <= sum_next[63:0];
            // value high part is carry minus addend sign: -1, 0 or +1
            s1_hi_neg_reg <= !sum_next[64] && item.addend[63];
            s1_hi_pos_reg <= sum_next[64] && !item.addend[63];
            s1_place_reg  <= item.place_addr;
            s1_offs_reg   <= item.offset_low_bits;
            s1_word_reg   <= item.existing_word;
        end
    end

    assign br_diff_next = {1'b0, s1_lo_reg} - {1'b0, s1_place_reg};
    assign pg_diff_next = {1'b0, s1_lo_reg[63:12]} - {1'b0, s1_place_reg[63:12]};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_kind_reg      <= s1_kind_reg;
            s2_lo_reg        <= s1_lo_reg;
            s2_hi_neg_reg    <= s1_hi_neg_reg;
            s2_hi_pos_reg    <= s1_hi_pos_reg;
            s2_offs_reg      <= s1_offs_reg;
            s2_word_reg      <= s1_word_reg;
            s2_br_dist_reg   <= br_diff_next[63:0];
            s2_br_borrow_reg <= br_diff_next[64];
            s2_pg_dist_reg   <= pg_diff_next[51:0];
            s2_pg_neg_reg    <= pg_diff_next[52];
        end
    end

    always_comb
    begin
        hi_zero     = !s2_hi_neg_reg && !s2_hi_pos_reg;
        dhi_zero    = (hi_zero && !s2_br_borrow_reg) || (s2_hi_pos_reg && s2_br_borrow_reg);
        dhi_minus1  = (s2_hi_neg_reg && !s2_br_borrow_reg) || (hi_zero && s2_br_borrow_reg);
        br_in_range = (dhi_zero && (s2_br_dist_reg[63:27] == '0)) ||
                      (dhi_minus1 && (s2_br_dist_reg[63:27] == '1));
        // page distance in 4k units: the signed byte distance must fit in 33 bits
        pg_in_range = (!s2_pg_neg_reg && (s2_pg_dist_reg[51:20] == '0)) ||
                      (s2_pg_neg_reg && (s2_pg_dist_reg[51:20] == '1));
        br_op       = (s2_kind_reg == arp_pkg::KIND_CALL) ? arp_pkg::OP_BL : arp_pkg::OP_B;
        pg_imm      = s2_pg_dist_reg[20:0];

        result_next.patched_word = '0;
        result_next.wide_write   = 1'b0;
        result_next.status       = arp_pkg::ST_OK;

        case (s2_kind_reg)
            arp_pkg::KIND_ABS64:
            begin
                if (s2_offs_reg != 3'd0 || !hi_zero)
                    result_next.status = arp_pkg::ST_ABS64_BAD;
                else
                begin
                    result_next.patched_word = s2_lo_reg;
                    result_next.wide_write   = 1'b1;
                end
            end
            arp_pkg::KIND_ABS32:
            begin
                if (s2_offs_reg[1:0] != 2'd0 || !hi_zero || s2_lo_reg[63:32] != '0)
                    result_next.status = arp_pkg::ST_ABS32_BAD;
                else
                    result_next.patched_word = {32'd0, s2_lo_reg[31:0]};
            end
            arp_pkg::KIND_CALL, arp_pkg::KIND_JUMP:
            begin
                if (s2_br_dist_reg[1:0] != 2'd0)
                    result_next.status = arp_pkg::ST_BR_MISALIGNED;
                else if (!br_in_range)
                    result_next.status = arp_pkg::ST_BR_RANGE;
                else if ((s2_word_reg & arp_pkg::MASK_BRANCH) != br_op)
                    result_next.status = arp_pkg::ST_NOT_BRANCH;
                else
                    result_next.patched_word = {32'd0, br_op[31:26], s2_br_dist_reg[27:2]};
            end
            arp_pkg::KIND_ADRP:
            begin
                if (s2_hi_neg_reg)
                    result_next.status = arp_pkg::ST_ADRP_NEGATIVE;
                else if (!pg_in_range)
                    result_next.status = arp_pkg::ST_ADRP_RANGE;
                else if ((s2_word_reg & arp_pkg::MASK_ADRP) != arp_pkg::OP_ADRP)
                    result_next.status = arp_pkg::ST_NOT_ADRP;
                else
                    result_next.patched_word = {32'd0,
                        (s2_word_reg & ~arp_pkg::IMM_ADRP) |
                        {1'b0, pg_imm[1:0], 5'd0, pg_imm[20:2], 5'd0}};
            end
            arp_pkg::KIND_ADDLO:
            begin
                if (s2_hi_neg_reg)
                    result_next.status = arp_pkg::ST_ADD_NEGATIVE;
                else if ((s2_word_reg & arp_pkg::MASK_ADD) != arp_pkg::OP_ADD)
                    result_next.status = arp_pkg::ST_NOT_ADD;
                else
                    result_next.patched_word = {32'd0,
                        (s2_word_reg & ~arp_pkg::IMM_ADD) |
                        {10'd0, s2_lo_reg[11:0], 10'd0}};
            end
            default:
                result_next.status = arp_pkg::ST_UNSUPPORTED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every accepted transaction comes out as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 result_valid)
        else $error("accepted transaction did not produce a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 3))
        else $error("result without a matching transaction");

    // a failed relocation writes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != arp_pkg::ST_OK) |->
            (result.patched_word == '0 && !result.wide_write))
        else $error("failing status with nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.wide_write) |-> (result.patched_word[63:32] == '0))
        else $error("narrow write with nonzero upper half");

endmodule

`default_nettype wire

@@ bench/tb_aarch64_relocation_patcher_core.sv @@
// self-checking testbench for the aarch64 relocation patcher core
`timescale 1ns / 1ps

module tb_aarch64_relocation_patcher_core;

    import arp_pkg::*;

    localparam int IDLE_LIMIT   = 500;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [65:0] BRANCH_SPAN = 66'sd134217728;
    localparam logic signed [64:0] PAGE_SPAN   = 65'sd4294967296;

    typedef struct {
        item_t   reloc;
        bit      typed;
        result_t want;
    } reloc_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_valid;
    result_t result;

    // typed-in expectation travels with the transaction it belongs to
    logic    drv_typed;
    result_t drv_exp;

    reloc_row_t directed_rows[$];
    result_t    patch_q[$];
    int         n_driven     = 0;
    int         results_seen = 0;
    int         errors       = 0;
    int         idle_cycles  = 0;
    bit         timed_out    = 0;
    bit         paused       = 0;

    aarch64_relocation_patcher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic result_t predict_reloc(input item_t r);
        logic signed [65:0] value;
        logic signed [65:0] br_dist;
        logic signed [64:0] page_dist;
        logic [63:0]        lo;
        logic signed [1:0]  hi;
        logic [63:0]        tpage;
        logic [63:0]        ppage;
        logic [31:0]        op;
        logic [20:0]        pimm;
        result_t            p;
        p = '0;
        value = $signed({2'b00, r.sym_value}) + $signed({{2{r.addend[63]}}, r.addend});
        lo = value[63:0];
        hi = value[65:64];
        case (r.opcode)
            RT_ABS64:
            begin
                if (r.offset_low_bits != 3'd0 || hi != 2'sd0)
                    p.status = ST_ABS64_BAD;
                else
                begin
                    p.patched_word = lo;
                    p.wide_write   = 1'b1;
                    p.status       = ST_OK;
                end
            end
            RT_ABS32:
            begin
                if (r.offset_low_bits[1:0] != 2'd0 || hi != 2'sd0 || lo[63:32] != 32'd0)
                    p.status = ST_ABS32_BAD;
                else
                begin
                    p.patched_word = lo;
                    p.status       = ST_OK;
                end
            end
            RT_CALL26, RT_JUMP26:
            begin
                br_dist = value - $signed({2'b00, r.place_addr});
                op = (r.opcode == RT_CALL26) ? OP_BL : OP_B;
                if (br_dist[1:0] != 2'd0)
                    p.status = ST_BR_MISALIGNED;
                else if (!(br_dist < BRANCH_SPAN && br_dist >= -BRANCH_SPAN))
                    p.status = ST_BR_RANGE;
                else if ((r.existing_word & MASK_BRANCH) != op)
                    p.status = ST_NOT_BRANCH;
                else
                begin
                    p.patched_word = {32'd0, op | {6'd0, br_dist[27:2]}};
                    p.status       = ST_OK;
                end
            end
            RT_ADRP:
            begin
                tpage = {lo[63:12], 12'd0};
                ppage = {r.place_addr[63:12], 12'd0};
                page_dist = $signed({1'b0, tpage}) - $signed({1'b0, ppage});
                pimm = page_dist[32:12];
                if (hi[1])
                    p.status = ST_ADRP_NEGATIVE;
                else if (!(page_dist < PAGE_SPAN && page_dist >= -PAGE_SPAN))
                    p.status = ST_ADRP_RANGE;
                else if ((r.existing_word & MASK_ADRP) != OP_ADRP)
                    p.status = ST_NOT_ADRP;
                else
                begin
                    p.patched_word = {32'd0, (r.existing_word & ~IMM_ADRP)
                                     | {1'b0, pimm[1:0], 29'd0} | {8'd0, pimm[20:2], 5'd0}};
                    p.status       = ST_OK;
                end
            end
            RT_ADDLO:
            begin
                if (hi[1])
                    p.status = ST_ADD_NEGATIVE;
                else if ((r.existing_word & MASK_ADD) != OP_ADD)
                    p.status = ST_NOT_ADD;
                else
                begin
                    p.patched_word = {32'd0, (r.existing_word & ~IMM_ADD)
                                     | {10'd0, lo[11:0], 10'd0}};
                    p.status       = ST_OK;
                end
            end
            default:
                p.status = ST_UNSUPPORTED;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // byte distance for a 2^lim_log2 signed range: small, anywhere inside, near its limits, or fully random
    function automatic logic [63:0] near_delta(input int lim_log2);
        logic [63:0] d;
        logic [15:0] s;
        logic [3:0]  n;
        s = 16'($urandom);
        n = 4'($urandom);
        case ($urandom_range(0, 3))
            0: d = {{48{s[15]}}, s};
            1:
            begin
                d = rand64() & ((64'd1 << (lim_log2 + 1)) - 64'd1);
                d = d - (64'd1 << lim_log2);
            end
            2:
            begin
                d = (64'd1 << lim_log2) + {{60{n[3]}}, n};
                if ($urandom_range(0, 1) == 1)
                    d = -d;
            end
            default: d = rand64();
        endcase
        return d;
    endfunction

    function automatic item_t make_reloc();
        item_t       r;
        logic [63:0] delta;
        logic [11:0] s;
        int          sel;
        r.opcode          = $urandom;
        r.place_addr      = rand64();
        r.sym_value       = rand64();
        r.addend          = rand64();
        r.offset_low_bits = 3'($urandom_range(0, 7));
        r.existing_word   = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            // noise: random types, some in the range around the supported ones
            if ($urandom_range(0, 1) == 1)
                r.opcode = 32'd256 + 32'($urandom_range(0, 31));
            return r;
        end
        s = 12'($urandom);
        if ($urandom_range(0, 3) != 0)
            r.addend = {{52{s[11]}}, s};
        case ((sel - 12) % 6)
            0:
            begin
                r.opcode = RT_ABS64;
                if ($urandom_range(0, 3) != 0)
                    r.offset_low_bits = 3'd0;
            end
            1:
            begin
                r.opcode = RT_ABS32;
                if ($urandom_range(0, 3) != 0)
                    r.sym_value = {32'd0, $urandom};
                if ($urandom_range(0, 3) != 0)
                    r.offset_low_bits = {r.offset_low_bits[2], 2'b00};
            end
            2, 3:
            begin
                r.opcode = ($urandom_range(0, 1) == 1) ? RT_CALL26 : RT_JUMP26;
                delta = near_delta(27);
                if ($urandom_range(0, 3) != 0)
                    delta[1:0] = 2'b00;
                r.sym_value = r.place_addr + delta - r.addend;
                if ($urandom_range(0, 7) != 0)
                    r.existing_word = (r.existing_word & ~MASK_BRANCH)
                                    | ((r.opcode == RT_CALL26) ? OP_BL : OP_B);
            end
            4:
            begin
                r.opcode = RT_ADRP;
                delta = near_delta(32);
                r.sym_value = r.place_addr + delta - r.addend;
                if ($urandom_range(0, 7) != 0)
                    r.existing_word = (r.existing_word & ~MASK_ADRP) | OP_ADRP;
            end
            default:
            begin
                r.opcode = RT_ADDLO;
                if ($urandom_range(0, 7) != 0)
                    r.existing_word = (r.existing_word & ~MASK_ADD) | OP_ADD;
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [31:0] opc, input logic [63:0] place,
                           input logic [63:0] sym, input logic [63:0] add,
                           input logic [2:0] offs, input logic [31:0] word,
                           input bit typed, input result_t want);
        reloc_row_t row;
        row.reloc.opcode          = opc;
        row.reloc.place_addr      = place;
        row.reloc.sym_value       = sym;
        row.reloc.addend          = add;
        row.reloc.offset_low_bits = offs;
        row.reloc.existing_word   = word;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic fill_table();
        // unsupported types at both ends of the opcode range
        add_row(32'd0, '1, '1, '1, 3'd7, '1, 1'b1, {64'd0, 1'b0, ST_UNSUPPORTED});
        add_row('1, 64'd0, 64'd0, 64'd0, 3'd0, 32'd0, 1'b1, {64'd0, 1'b0, ST_UNSUPPORTED});
        // abs64: plain, misaligned, carry out, negative, full scale
        add_row(RT_ABS64, 64'd0, 64'h1000, 64'h10, 3'd0, 32'd0, 1'b1,
                {64'h1010, 1'b1, ST_OK});
        add_row(RT_ABS64, 64'd0, 64'h1000, 64'd0, 3'd7, 32'd0, 1'b1,
                {64'd0, 1'b0, ST_ABS64_BAD});
        add_row(RT_ABS64, 64'd0, '1, 64'd1, 3'd0, 32'd0, 1'b1, {64'd0, 1'b0, ST_ABS64_BAD});
        add_row(RT_ABS64, 64'd0, 64'd0, '1, 3'd0, 32'd0, 1'b1, {64'd0, 1'b0, ST_ABS64_BAD});
        add_row(RT_ABS64, '1, '1, 64'd0, 3'd0, '1, 1'b1,
                {64'hffff_ffff_ffff_ffff, 1'b1, ST_OK});
        // abs32: top of range with offset 4, just above range, misaligned
        add_row(RT_ABS32, 64'd0, 64'hffff_ffff, 64'd0, 3'd4, 32'd0, 1'b1,
                {64'hffff_ffff, 1'b0, ST_OK});
        add_row(RT_ABS32, 64'd0, 64'h1_0000_0000, 64'd0, 3'd0, 32'd0, 1'b1,
                {64'd0, 1'b0, ST_ABS32_BAD});
        add_row(RT_ABS32, 64'd0, 64'h10, 64'd0, 3'd2, 32'd0, 1'b1,
                {64'd0, 1'b0, ST_ABS32_BAD});
        // branches: farthest forward and backward, one past, misaligned, wrong opcode
        add_row(RT_CALL26, 64'h1000, 64'h1000, 64'h7ff_fffc, 3'd5, OP_BL, 1'b0, '0);
        add_row(RT_JUMP26, 64'h1000_0000, 64'h0800_0000, 64'd0, 3'd0, 32'h17ff_ffff,
                1'b0, '0);
        add_row(RT_CALL26, 64'd0, 64'h0800_0000, 64'd0, 3'd0, OP_BL, 1'b1,
                {64'd0, 1'b0, ST_BR_RANGE});
        add_row(RT_CALL26, 64'd0, 64'd2, 64'd0, 3'd0, OP_BL, 1'b1,
                {64'd0, 1'b0, ST_BR_MISALIGNED});
        add_row(RT_JUMP26, 64'd0, 64'h100, 64'd0, 3'd0, OP_BL, 1'b1,
                {64'd0, 1'b0, ST_NOT_BRANCH});
        // adrp: negative value, normal, page range limits, wrong word, value past 2^64
        add_row(RT_ADRP, 64'd0, 64'd0, '1, 3'd0, OP_ADRP, 1'b1,
                {64'd0, 1'b0, ST_ADRP_NEGATIVE});
        add_row(RT_ADRP, 64'h40_0000, 64'h1234_5678, 64'd0, 3'd3, 32'h9000_0005, 1'b0, '0);
        add_row(RT_ADRP, 64'h1000, 64'h1_0000_1000, 64'd0, 3'd0, OP_ADRP, 1'b1,
                {64'd0, 1'b0, ST_ADRP_RANGE});
        add_row(RT_ADRP, 64'h1_0000_0000, 64'd0, 64'd0, 3'd0, 32'hf0ff_ffff, 1'b0, '0);
        add_row(RT_ADRP, 64'h5000, 64'h5000, 64'd0, 3'd0, 32'd0, 1'b1,
                {64'd0, 1'b0, ST_NOT_ADRP});
        add_row(RT_ADRP, 64'h1000, '1, 64'h2000, 3'd0, 32'h9000_001f, 1'b0, '0);
        // add lo12: most negative addend, normal, wrong word, value past 2^64
        add_row(RT_ADDLO, 64'd0, 64'd0, 64'h8000_0000_0000_0000, 3'd0, OP_ADD, 1'b1,
                {64'd0, 1'b0, ST_ADD_NEGATIVE});
        add_row(RT_ADDLO, 64'd0, 64'h123, 64'h7fff_ffff_ffff_ffff, 3'd0, 32'h9100_0421,
                1'b0, '0);
        add_row(RT_ADDLO, 64'd0, 64'h10, 64'd0, 3'd0, 32'h1140_0000, 1'b1,
                {64'd0, 1'b0, ST_NOT_ADD});
        add_row(RT_ADDLO, 64'd0, '1, 64'h7fff_ffff_ffff_ffff, 3'd0, 32'h9100_0000,
                1'b0, '0);
    endtask

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_reloc(input item_t r, input bit typed, input result_t want);
        bit taken;
        start     <= 1'b1;
        item      <= r;
        drv_typed <= typed;
        drv_exp   <= want;
        taken = 1'b0;
        while (!taken && !timed_out)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        n_driven++;
    endtask

    task automatic wait_drained();
        while (results_seen < n_driven && !timed_out)
            @(negedge clk);
        @(posedge clk);
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                patch_q.insert(patch_q.size(), drv_typed ? drv_exp : predict_reloc(item));
            if (result_valid)
            begin
                results_seen++;
                if (patch_q.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected result: word %h wide %b status %0d",
                                 result.patched_word, result.wide_write, result.status);
                    errors++;
                end
                else
                begin
                    want = patch_q.pop_front();
                    if (result.patched_word !== want.patched_word
                        || result.wide_write !== want.wide_write
                        || result.status !== want.status)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("mismatch: word %h/%h wide %b/%b status %0d/%0d (exp/got)",
                                     want.patched_word, result.patched_word,
                                     want.wide_write, result.wide_write,
                                     want.status, result.status);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        int    i;
        int    n;
        int    burst;
        int    gap;
        bit    hold;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        drv_typed = 1'b0;
        drv_exp   = '0;
        fill_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size() && !timed_out; i++)
            send_reloc(directed_rows[i].reloc, directed_rows[i].typed, directed_rows[i].want);
        start <= 1'b0;
        wait_drained();

        i = 0;
        while (i < RANDOM_ITEMS && !timed_out)
        begin
            burst = $urandom_range(1, 24);
            for (n = 0; n < burst && i < RANDOM_ITEMS && !timed_out; n++)
            begin
                send_reloc(make_reloc(), 1'b0, '0);
                i++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            // once in the middle, hold off until the pipeline has emptied
            hold = (i >= RANDOM_ITEMS / 2) && !paused;
            if (gap > 0 || hold)
            begin
                start <= 1'b0;
                if (hold)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        if (patch_q.size() != 0)
        begin
            if (errors < MAX_REPORTS)
                $display("%0d expected results never arrived", patch_q.size());
            errors += patch_q.size();
        end

        if (!timed_out && errors == 0)
            $display("tb_aarch64_relocation_patcher_core passed");
        else
            $display("tb_aarch64_relocation_patcher_core failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/arp_pkg.sv
hw/rtl/aarch64_relocation_patcher_core.sv
bench/tb_aarch64_relocation_patcher_core.sv
